// ===== rtl/core/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// Markov token sampler package
// Shared opcodes and fixed field widths of the sampler channels.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int OpcodeBits = 3;
  localparam int IndexBits  = 12;
  localparam int StartBits  = 12;
  localparam int CountBits  = 13;
  localparam int ValueBits  = 16;
  localparam int BiasBits   = 16;
  localparam int OutTokBits = 16;
  localparam int TotalBits  = 32;
  localparam int CfgIdxBits = 2;
  localparam int CfgDatBits = 32;

  localparam logic [OpcodeBits-1:0] OP_WRITE_CELL = 3'd0;
  localparam logic [OpcodeBits-1:0] OP_WRITE_EMIT = 3'd1;
  localparam logic [OpcodeBits-1:0] OP_SET_CTX    = 3'd2;
  localparam logic [OpcodeBits-1:0] OP_GENERATE   = 3'd3;
  localparam logic [OpcodeBits-1:0] OP_RESTART    = 3'd4;

  localparam logic [CfgIdxBits-1:0] REG_NUM_CELLS = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_NUM_EMITS = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_RNG_SEED  = 2'd2;

  localparam logic [31:0] DEFAULT_SEED = 32'hDEADBEEF;

  typedef struct packed {
    logic [OpcodeBits-1:0] opcode;
    logic [IndexBits-1:0]  table_index;
    logic [StartBits-1:0]  range_start;
    logic [CountBits-1:0]  range_count;
    logic [ValueBits-1:0]  token_value;
    logic [BiasBits-1:0]   bias_value;
  } mts_in_t;

  typedef struct packed {
    logic [OutTokBits-1:0] token;
    logic                  fallback;
    logic [TotalBits-1:0]  generated_total;
  } mts_out_t;

endpackage

// ===== rtl/core/mts_if.sv =====
// ----------------------------------------------------------------------------
// Markov token sampler channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface mts_in_if
  import mts_pkg::*;
();
  logic    valid;
  logic    ready;
  mts_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mts_out_if
  import mts_pkg::*;
();
  logic     valid;
  logic     ready;
  mts_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/markov_token_sampler_top.sv =====
// ----------------------------------------------------------------------------
// Markov token sampler
// Table-driven Markov token generator with history penalty and xorshift32
// weighted pick, run by a small sequencer around one shared subtractor.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// in_      in   opcode, table_index, range_start, range_count, token_value,
//               bias_value
// out_     out  token, fallback, generated_total (generate only)
// cfg_     in   write enable, register index, write data
//
// A table write, context set, restart or unused opcode passes through a
// wait state before the block takes the next item. A generate runs the
// cell index remainder, the cell read, a scan of the emits in which each
// is compared with the history one entry per cycle, then, when there is a
// candidate, the draw remainder and P pick steps (1 to MAX_PICKS); its
// result may stall. Both remainders are 32-step shift-subtract.
// The block takes no item while one is at work or its result waits.
// Reset is synchronous; memories are not cleared.
// ----------------------------------------------------------------------------
module markov_token_sampler_top
  import mts_pkg::*;
#(
  parameter int CELL_DEPTH  = 1024,
  parameter int EMIT_DEPTH  = 4096,
  parameter int HISTORY_LEN = 12,
  parameter int MAX_PICKS   = 8,
  parameter int TOKEN_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mts_in_if.sink                in_ch,
  mts_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CfgIdxBits-1:0] cfg_index,
  input  logic [CfgDatBits-1:0] cfg_data
);

  localparam int CAW = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
  localparam int EAW = (EMIT_DEPTH > 1) ? $clog2(EMIT_DEPTH) : 1;
  localparam int HSW = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
  localparam int PKW = $clog2(MAX_PICKS + 1);
  localparam int PIW = (MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1;
  localparam int TB  = TOKEN_BITS;
  localparam int SW  = BiasBits + PKW;  // total score width
  localparam int EW  = 17;              // emit index / end width

  localparam logic [3:0] S_IDLE = 4'd0, S_CMOD = 4'd1, S_CRD = 4'd2,
    S_CEND = 4'd3, S_ERD = 4'd4, S_HIST = 4'd5, S_RMOD = 4'd6,
    S_PICK = 4'd7, S_DONE = 4'd8, S_OUT = 4'd9, S_CWAIT = 4'd10;

  // Memories.
  logic [StartBits+CountBits-1:0] cell_mem [CELL_DEPTH];
  logic [TB+BiasBits-1:0]         emit_mem [EMIT_DEPTH];
  logic [StartBits+CountBits-1:0] cell_q_r;
  logic [TB+BiasBits-1:0]         emit_q_r;

  logic [3:0]  state_r, state_nxt;
  logic [10:0] num_cells_r;
  logic [12:0] num_emits_r;
  logic [31:0] rng_seed_r, rand_r;
  logic [TB-1:0] hist_r [HISTORY_LEN];
  logic [HSW-1:0] hslot_r, hidx_r;
  logic [TB-1:0]  cur_r;
  logic [31:0]    count_r;
  logic [TB-1:0]  ids_r [MAX_PICKS];
  logic [BiasBits-1:0] sc_r [MAX_PICKS];
  logic [PKW-1:0] n_r;
  logic [PIW-1:0] pi_r;
  logic [EW-1:0]  e_r, end_r;
  logic [SW-1:0]  total_r, cum_r;
  logic [32+SW-1:0] rem_r;     // shift-subtract remainder register
  logic [5:0]     bit_r;
  logic [CAW-1:0] cidx_r;
  logic [TB-1:0]  chosen_r;
  logic           hit_r, fb_r, oval_r;
  logic [CAW:0]   ncell;
  logic [EW-1:0]  nemit;

  // Clamped register values.
  always_comb begin
    if (num_cells_r == 11'd0) ncell = (CAW+1)'(1);
    else if (32'(num_cells_r) > 32'(CELL_DEPTH)) ncell = (CAW+1)'(CELL_DEPTH);
    else ncell = (CAW+1)'(num_cells_r);
    if (32'(num_emits_r) > 32'(EMIT_DEPTH)) nemit = EW'(EMIT_DEPTH);
    else nemit = EW'(num_emits_r);
  end

  assign in_ch.ready = (state_r == S_IDLE);
  logic acc;
  assign acc = in_ch.valid && in_ch.ready;
  mts_in_t req;
  assign req = in_ch.payload;

  // Shared subtractor: remainder window minus divisor.
  logic [SW:0]   sub_a, sub_b, sub_d;
  logic [SW-1:0] mod_rem;
  always_comb begin
    if (state_r == S_CMOD) begin
      sub_b = (SW+1)'(ncell);
    end else begin
      sub_b = (SW+1)'(total_r);
    end
    sub_a = {rem_r[32+SW-1:32], rem_r[31]};
    sub_d = sub_a - sub_b;
  end
  assign mod_rem = (!sub_d[SW]) ? sub_d[SW-1:0] : sub_a[SW-1:0];

  logic [TB-1:0]       e_tok;
  logic [BiasBits-1:0] e_bias, e_sc;
  logic                hit_now;
  assign e_tok   = emit_q_r[TB+BiasBits-1:BiasBits];
  assign e_bias  = emit_q_r[BiasBits-1:0];
  assign hit_now = hit_r || (hist_r[hidx_r] == e_tok);
  assign e_sc    = hit_now ? (e_bias >> 2) : e_bias;

  logic [31:0] x1, x2, x3;
  assign x1 = rand_r ^ (rand_r << 13);
  assign x2 = x1 ^ (x1 >> 17);
  assign x3 = x2 ^ (x2 << 5);

  logic [SW-1:0] cum_add;
  assign cum_add = cum_r + SW'(sc_r[pi_r]);

  // Scan and pick conditions.
  logic scan_more, hist_last, pick_hit, pick_last;
  assign scan_more = (e_r < end_r) && (32'(n_r) < 32'(MAX_PICKS));
  assign hist_last = (32'(hidx_r) == 32'(HISTORY_LEN - 1));
  assign pick_hit  = (cum_add > rem_r[SW-1:0]);
  assign pick_last = (32'(pi_r) + 1 >= 32'(n_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (acc) begin
        if (req.opcode == OP_GENERATE) state_nxt = S_CMOD;
        else state_nxt = S_CWAIT;
      end
      S_CMOD:  if (bit_r == 6'd0) state_nxt = S_CRD;
      S_CRD:   state_nxt = S_CEND;
      S_CEND:  state_nxt = S_ERD;
      S_ERD: begin
        if (scan_more) state_nxt = S_HIST;
        else if (n_r != '0) state_nxt = S_RMOD;
        else state_nxt = S_DONE;
      end
      S_HIST:  if (hist_last) state_nxt = S_ERD;
      S_RMOD:  if (bit_r == 6'd0) state_nxt = S_PICK;
      S_PICK:  if (pick_hit || pick_last) state_nxt = S_DONE;
      S_DONE:  state_nxt = S_OUT;
      S_OUT:   if (out_ch.ready) state_nxt = S_IDLE;
      S_CWAIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    if (acc && req.opcode == OP_WRITE_CELL && 32'(req.table_index) < 32'(CELL_DEPTH))
      cell_mem[CAW'(req.table_index)] <= {req.range_start, req.range_count};
    if (acc && req.opcode == OP_WRITE_EMIT && 32'(req.table_index) < 32'(EMIT_DEPTH))
      emit_mem[EAW'(req.table_index)] <= {TB'(req.token_value), req.bias_value};
    cell_q_r <= cell_mem[cidx_r];
    emit_q_r <= emit_mem[EAW'(e_r)];
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      num_cells_r <= 11'd1;
      num_emits_r <= 13'd0;
      rng_seed_r <= DEFAULT_SEED;
      rand_r <= DEFAULT_SEED;
      for (int i = 0; i < HISTORY_LEN; i++) hist_r[i] <= '0;
      hslot_r <= '0;
      cur_r <= '0;
      count_r <= '0;
      oval_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_CELLS: num_cells_r <= cfg_data[10:0];
          REG_NUM_EMITS: num_emits_r <= cfg_data[12:0];
          REG_RNG_SEED:  rng_seed_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (acc) begin
          case (req.opcode)
            OP_SET_CTX: cur_r <= TB'(req.token_value);
            OP_RESTART: begin
              for (int i = 0; i < HISTORY_LEN; i++) hist_r[i] <= '0;
              hslot_r <= '0;
              cur_r <= '0;
              count_r <= '0;
              rand_r <= (rng_seed_r != 32'd0) ? rng_seed_r : DEFAULT_SEED;
            end
            OP_GENERATE: begin
              rem_r <= {(SW)'(0), 32'(cur_r)};
              bit_r <= 6'd31;
              n_r <= '0;
            end
            default: ;
          endcase
        end
        // Bit-serial remainder: cell index first, then the draw.
        S_CMOD, S_RMOD: begin
          if (bit_r != 6'd0) begin
            rem_r <= {mod_rem, rem_r[30:0], 1'b0};
            bit_r <= bit_r - 6'd1;
          end else if (state_r == S_CMOD) begin
            cidx_r <= CAW'(mod_rem);
          end else begin
            rem_r <= (32+SW)'(mod_rem);
            pi_r <= '0;
            cum_r <= '0;
            chosen_r <= ids_r[0];
          end
        end
        S_CEND: begin
          e_r <= EW'(cell_q_r[StartBits+CountBits-1:CountBits]);
          if (EW'(cell_q_r[StartBits+CountBits-1:CountBits]) +
              EW'(cell_q_r[CountBits-1:0]) > nemit)
            end_r <= nemit;
          else
            end_r <= EW'(cell_q_r[StartBits+CountBits-1:CountBits]) +
                     EW'(cell_q_r[CountBits-1:0]);
        end
        // Leaving the scan with candidates advances the generator.
        S_ERD: begin
          hidx_r <= '0;
          hit_r <= 1'b0;
          if (!scan_more && n_r != '0) begin
            rand_r <= x3;
            rem_r <= {SW'(0), x3};
            bit_r <= 6'd31;
          end
        end
        // One history entry compared per cycle, then the score is taken.
        S_HIST: begin
          hit_r <= hit_now;
          if (hist_last) begin
            if (e_sc != '0) begin
              ids_r[PIW'(n_r)] <= e_tok;
              sc_r[PIW'(n_r)] <= e_sc;
              n_r <= n_r + PKW'(1);
            end
            e_r <= e_r + EW'(1);
          end else hidx_r <= hidx_r + HSW'(1);
        end
        S_PICK: begin
          if (pick_hit) chosen_r <= ids_r[pi_r];
          cum_r <= cum_add;
          pi_r <= pi_r + PIW'(1);
        end
        S_DONE: begin
          oval_r <= 1'b1;
          if (n_r == '0) begin
            fb_r <= 1'b1;
            cur_r <= '0;
          end else begin
            fb_r <= 1'b0;
            hist_r[hslot_r] <= chosen_r;
            hslot_r <= (32'(hslot_r) + 1 >= 32'(HISTORY_LEN)) ? '0 : hslot_r + HSW'(1);
            cur_r <= chosen_r;
            count_r <= count_r + 32'd1;
          end
        end
        S_OUT: if (out_ch.ready) oval_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // Total score of the candidates, summed as they arrive.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) total_r <= '0;
    else if (state_r == S_HIST && hist_last)
      total_r <= total_r + SW'(e_sc);
  end

  assign out_ch.valid = oval_r && state_r == S_OUT;
  assign out_ch.payload.token = fb_r ? '0 : OutTokBits'(chosen_r);
  assign out_ch.payload.fallback = fb_r;
  assign out_ch.payload.generated_total = count_r;

endmodule
